@@ hw/rtl/hcbp_pkg.sv @@
// Shared constants and types for the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;

	localparam int SYM_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int BYTE_W = 8;
	localparam int PAD_W  = 3;
	localparam int ACC_W  = BYTE_W + CODE_W;
	localparam int CNT_W  = 6;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 3;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QCNT_W  = 3;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_ENCODE = 1'b1;

	typedef struct packed {
		logic              eod;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} item_t;

endpackage
`default_nettype wire

@@ hw/rtl/hcbp_front.sv @@
// Front end: beat intake, code table load and lookup.
`default_nettype none
module hcbp_front #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [hcbp_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [hcbp_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic                           s_tlast,
	input  wire logic [hcbp_pkg::QCNT_W-1:0]    q_count,
	output logic                                q_push,
	output hcbp_pkg::item_t                     q_item
);
	localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_LIMIT = (MAX_CODE_LEN > hcbp_pkg::CODE_W) ? hcbp_pkg::CODE_W
		: MAX_CODE_LEN;
	localparam int ENT_W = hcbp_pkg::LEN_W + hcbp_pkg::CODE_W;

	logic [hcbp_pkg::SYM_W-1:0]  symbol;
	logic [hcbp_pkg::CODE_W-1:0] code_value;
	logic [hcbp_pkg::LEN_W-1:0]  code_length;
	logic                        in_range;
	logic [IDX_W-1:0]            idx;
	logic                        accept;
	logic                        wr;
	logic                        rd;
	logic [hcbp_pkg::QCNT_W:0]   used;

	logic [ENT_W-1:0]        mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] vld_q;
	logic [ENT_W-1:0]        ent_s1;
	logic                    valid_s1;
	logic                    hit_s1;
	logic                    eod_s1;

	assign symbol      = s_tdata[7:0];
	assign code_value  = s_tdata[39:8];
	assign code_length = s_tdata[45:40];

	assign in_range = {1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
	assign idx      = symbol[IDX_W-1:0];

	// room for this beat and the one already in the lookup stage
	assign used     = {1'b0, q_count} + {{hcbp_pkg::QCNT_W{1'b0}}, valid_s1};
	assign s_tready = used < (hcbp_pkg::QCNT_W + 1)'(hcbp_pkg::QDEPTH);
	assign accept   = s_tvalid && s_tready;

	assign wr = accept && (s_tuser[0] == hcbp_pkg::OP_LOAD) && in_range &&
		(code_length <= hcbp_pkg::LEN_W'(LEN_LIMIT));
	assign rd = accept && (s_tuser[0] == hcbp_pkg::OP_ENCODE);

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[idx] <= {code_length, code_value};
		end
		if (rd) begin
			ent_s1 <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
			eod_s1   <= 1'b0;
		end else begin
			if (wr) begin
				vld_q[idx] <= 1'b1;
			end
			valid_s1 <= rd;
			if (rd) begin
				hit_s1 <= in_range && vld_q[idx];
				eod_s1 <= s_tlast;
			end
		end
	end

	assign q_push      = valid_s1;
	assign q_item.eod  = eod_s1;
	assign q_item.len  = hit_s1 ? ent_s1[ENT_W-1:hcbp_pkg::CODE_W] : '0;
	assign q_item.bits = ent_s1[hcbp_pkg::CODE_W-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/hcbp_queue.sv @@
// Short FIFO between the lookup front end and the bit packer.
`default_nettype none
module hcbp_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire hcbp_pkg::item_t             push_item,
	input  wire logic                        pop,
	output logic                             head_valid,
	output hcbp_pkg::item_t                  head,
	output logic [hcbp_pkg::QCNT_W-1:0]      count
);
	hcbp_pkg::item_t                  mem [hcbp_pkg::QDEPTH];
	logic [hcbp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [hcbp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [hcbp_pkg::QCNT_W-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_valid = count_q != '0;
	assign head       = mem[rd_ptr_q];
	assign count      = count_q;

endmodule
`default_nettype wire

@@ hw/rtl/hcbp_back.sv @@
// Back end: MSB-first bit accumulator and registered byte output.
`default_nettype none
module hcbp_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           head_valid,
	input  wire hcbp_pkg::item_t                head,
	output logic                                pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [hcbp_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [hcbp_pkg::M_TUSER_W-1:0]      m_tuser,
	output logic                                m_tlast
);
	localparam int ACC_W = hcbp_pkg::ACC_W;
	localparam int CNT_W = hcbp_pkg::CNT_W;
	localparam int BW    = hcbp_pkg::BYTE_W;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             eod_q;
	logic             m_tvalid_q;
	logic [BW-1:0]    m_tdata_q;
	logic [hcbp_pkg::PAD_W-1:0] m_tuser_q;
	logic             m_tlast_q;

	logic             out_free;
	logic             full_byte;
	logic             emit;
	logic [CNT_W-1:0] cnt_e;
	logic [ACC_W-1:0] acc_e;
	logic             eod_e;
	logic [ACC_W-1:0] cw;
	logic [ACC_W-1:0] acc_n;
	logic [CNT_W-1:0] cnt_n;
	logic             eod_n;

	always_comb begin
		out_free  = !m_tvalid_q || m_tready;
		full_byte = cnt_q >= CNT_W'(BW);
		emit      = out_free && (full_byte || (eod_q && cnt_q != '0));
		cnt_e     = cnt_q;
		acc_e     = acc_q;
		if (emit) begin
			cnt_e = full_byte ? cnt_q - CNT_W'(BW) : '0;
			acc_e = acc_q << BW;
		end
		eod_e = eod_q && (cnt_e != '0);
		pop   = head_valid && (cnt_e < CNT_W'(BW)) && !eod_e;
		// code left-aligned at the accumulator top, bits above its length dropped
		cw    = {head.bits, {BW{1'b0}}} << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - head.len);
		acc_n = acc_e;
		cnt_n = cnt_e;
		eod_n = eod_e;
		if (pop) begin
			acc_n = acc_e | (cw >> cnt_e);
			cnt_n = cnt_e + CNT_W'(head.len);
			eod_n = head.eod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			cnt_q      <= '0;
			eod_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			acc_q <= acc_n;
			cnt_q <= cnt_n;
			eod_q <= eod_n;
			if (out_free) begin
				m_tvalid_q <= emit;
			end
			if (emit) begin
				m_tdata_q <= acc_q[ACC_W-1 -: BW];
				m_tuser_q <= full_byte ? '0 : hcbp_pkg::PAD_W'(CNT_W'(BW) - cnt_q);
				m_tlast_q <= eod_q && (cnt_q <= CNT_W'(BW));
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

@@ hw/rtl/huffman_code_bit_packer.sv @@
// Huffman code bit packer: top level.
//
// Input stream s_*: tuser[0] is the opcode (load a code table entry, or
// encode one symbol), tdata carries symbol, code bits and code length, tlast
// marks the final symbol of a stream. Output stream m_*: one packed byte per
// beat, earliest code bit in bit 7; tuser gives the pad bit count and tlast
// marks the final byte of a stream.
// A load updates the table at its accepting edge; an encode of the same
// symbol may follow in the very next beat. An encoded symbol is read from
// the table into the lookup stage register, queued, merged into the
// accumulator and registered into the output byte; stalls can come between.
// Throughput: one input beat per cycle while s_tready is high and one output
// byte per cycle while m_tready allows. The output byte rate bounds input: a
// symbol that completes k bytes holds the back end until all k are out, and
// the four-entry queue then fills and drops s_tready. The table is one
// synchronous-read memory port with a valid bit per entry.
// Reset clears the table valid bits (every symbol unused), the partial byte
// and the queue. A stalled m_tready holds the output register; the queue and
// the accumulator absorb the difference until s_tready falls.
`default_nettype none
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
	parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// symbol[7:0], code_value[39:8], code_length[45:40], zero[47:46]
	input  wire logic [hcbp_pkg::S_TDATA_W-1:0] s_tdata,
	// opcode[0]
	input  wire logic [hcbp_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// out_byte[7:0]
	output logic [hcbp_pkg::M_TDATA_W-1:0]      m_tdata,
	// pad_bits[2:0]
	output logic [hcbp_pkg::M_TUSER_W-1:0]      m_tuser,
	output logic                                m_tlast
);
	logic                            q_push;
	hcbp_pkg::item_t                 q_item;
	logic                            q_pop;
	logic                            q_valid;
	hcbp_pkg::item_t                 q_head;
	logic [hcbp_pkg::QCNT_W-1:0]     q_count;

	hcbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_count  (q_count),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	hcbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head),
		.count      (q_count)
	);

	hcbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// pad bits only on the final byte
	a_pad_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != '0) |-> m_tlast)
		else $error("pad bits on a non-final byte");

	// queue never overflows
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |-> q_count < hcbp_pkg::QCNT_W'(hcbp_pkg::QDEPTH))
		else $error("queue overflow");

	// never pop an empty queue
	a_queue_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_count != '0)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for huffman_code_bit_packer: table loads, code packing and flushes.
`default_nettype none
module tb_top;
	import hcbp_pkg::*;

	localparam int LEN_LIMIT     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int STALL_LIMIT   = 1000;
	localparam int HOLD_CYCLES   = 150;
	localparam int RANDOM_ITEMS  = 70;
	localparam int CALM_ITEMS    = 20;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [PAD_W-1:0]  pad;
		logic              last;
	} packed_byte_t;

	class packed_byte_scoreboard;
		logic [CODE_W-1:0] code_bits[SYMBOL_COUNT];
		logic [LEN_W-1:0]  code_len[SYMBOL_COUNT];
		logic [BYTE_W-1:0] fill_byte;
		int unsigned       fill_cnt;
		packed_byte_t      expected_bytes[$];

		function new();
			foreach (code_len[i]) begin
				code_bits[i] = '0;
				code_len[i]  = '0;
			end
			fill_byte = '0;
			fill_cnt  = 0;
		endfunction

		// Accepted input beat: update the table or append the symbol's code bits.
		function void note_input(logic op, logic [SYM_W-1:0] sym, logic [CODE_W-1:0] val,
				logic [LEN_W-1:0] len, logic eod);
			packed_byte_t made[5];
			int unsigned  n;
			int unsigned  i;
			n = 0;
			if (op == OP_LOAD) begin
				if (sym < SYMBOL_COUNT && len <= LEN_LIMIT) begin
					code_bits[sym] = val;
					code_len[sym]  = len;
				end
				return;
			end
			if (sym < SYMBOL_COUNT) begin
				for (i = code_len[sym]; i > 0; i--) begin
					fill_byte[7 - fill_cnt] = code_bits[sym][i - 1];
					fill_cnt++;
					if (fill_cnt == 8) begin
						made[n] = '{data: fill_byte, pad: '0, last: 1'b0};
						n++;
						fill_byte = '0;
						fill_cnt  = 0;
					end
				end
			end
			if (eod) begin
				if (fill_cnt != 0) begin
					made[n] = '{data: fill_byte, pad: PAD_W'(8 - fill_cnt), last: 1'b1};
					n++;
				end else if (n > 0) begin
					made[n - 1].last = 1'b1;
				end
				fill_byte = '0;
				fill_cnt  = 0;
			end
			for (i = 0; i < n; i++)
				expected_bytes = {expected_bytes, made[i]};
		endfunction

		// Returns an empty string on a match, else a description of the fault.
		function string check_byte(packed_byte_t got);
			packed_byte_t want;
			string        msg;
			if (expected_bytes.size() == 0)
				return $sformatf("unexpected byte %02h pad %0d last %0b",
					got.data, got.pad, got.last);
			want = expected_bytes.pop_front();
			msg  = "";
			if (got.data !== want.data)
				msg = {msg, $sformatf(" byte %02h/%02h", got.data, want.data)};
			if (got.pad !== want.pad)
				msg = {msg, $sformatf(" pad %0d/%0d", got.pad, want.pad)};
			if (got.last !== want.last)
				msg = {msg, $sformatf(" last %0b/%0b", got.last, want.last)};
			if (msg != "")
				msg = {"got/expected:", msg};
			return msg;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 s_tlast  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 m_tlast;

	packed_byte_scoreboard sb;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;
	bit          gaps_on = 1'b1;
	bit          jitter_on = 1'b1;
	bit          hold_req = 1'b0;
	int          live_syms[$];

	huffman_code_bit_packer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Offer one beat; valid stays high afterwards unless the next call opens a gap.
	task automatic send_beat(input logic op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] val, input logic [LEN_W-1:0] len, input logic eod);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, len, val, sym};
		s_tlast  <= eod;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, sym, val, len, eod);
	endtask

	task automatic load_sym(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] val,
			input logic [LEN_W-1:0] len, input logic eod);
		send_beat(OP_LOAD, sym, val, len, eod);
	endtask

	task automatic encode_sym(input logic [SYM_W-1:0] sym, input logic eod);
		send_beat(OP_ENCODE, sym, $urandom, LEN_W'($urandom), eod);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (jitter_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		string msg;
		if (arst_n && m_tvalid && m_tready) begin
			msg = sb.check_byte('{data: m_tdata, pad: m_tuser, last: m_tlast});
			if (msg != "")
				report_mismatch(msg);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned n_items;
		int unsigned n_loads;
		int unsigned n_enc;
		int unsigned sel;
		int unsigned k;
		int          sym;
		logic [LEN_W-1:0] len;
		sb = new();
		n_items = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: table extremes, ignored loads, flush corner cases
		load_sym(8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0);
		load_sym(8'hFF, 32'h8000_0001, 6'd1, 1'b0);
		load_sym(8'h55, 32'h0000_0000, 6'd32, 1'b0);
		load_sym(8'hAA, 32'h5A5A_5A5A, 6'd63, 1'b0);   // too long, dropped
		load_sym(8'h0F, 32'h1234_5678, 6'd33, 1'b0);   // too long, dropped
		load_sym(8'h80, 32'hFFFF_FFF3, 6'd2, 1'b1);    // end flag ignored on load
		load_sym(8'h7F, 32'hDEAD_BEEF, 6'd0, 1'b0);    // explicit unused symbol
		encode_sym(8'hAA, 1'b1);                       // empty stream: no bytes
		encode_sym(8'h00, 1'b0);
		encode_sym(8'hFF, 1'b0);
		encode_sym(8'h7F, 1'b0);
		encode_sym(8'h80, 1'b0);
		encode_sym(8'h0F, 1'b1);                       // flush of partial byte
		load_sym(8'h10, 32'h0000_00A5, 6'd8, 1'b0);
		encode_sym(8'h10, 1'b1);                       // byte completed on the last beat
		encode_sym(8'h55, 1'b0);
		encode_sym(8'hFF, 1'b1);                       // seven pad bits
		load_sym(8'h0F, 32'hFFFE_0000, 6'd17, 1'b0);
		encode_sym(8'h80, 1'b0);
		encode_sym(8'h80, 1'b0);
		encode_sym(8'h80, 1'b0);
		encode_sym(8'hFF, 1'b0);
		encode_sym(8'h00, 1'b1);                       // five bytes from one beat
		encode_sym(8'h0F, 1'b1);
		live_syms = '{8'h00, 8'hFF, 8'h55, 8'h80, 8'h10, 8'h0F};

		// back-pressure: long codes while the receiver holds off
		load_sym(8'hC3, $urandom, 6'd32, 1'b0);
		load_sym(8'h3C, $urandom, 6'd31, 1'b0);
		hold_req = 1'b1;
		for (k = 0; k < 12; k++) begin
			encode_sym(k[0] ? 8'h3C : 8'hC3, k == 11);
			n_items++;
		end

		while (n_items < RANDOM_ITEMS) begin
			if (n_items >= RANDOM_ITEMS - CALM_ITEMS) begin
				gaps_on   = 1'b0;
				jitter_on = 1'b0;
			end
			n_loads = $urandom_range(0, 3);
			for (k = 0; k < n_loads; k++) begin
				sym = $urandom_range(0, SYMBOL_COUNT - 1);
				sel = $urandom_range(0, 15);
				if (sel == 0)
					len = '0;
				else if (sel == 1)
					len = LEN_W'($urandom_range(LEN_LIMIT + 1, 63));
				else if (sel < 4)
					len = LEN_W'($urandom_range(13, LEN_LIMIT));
				else
					len = LEN_W'($urandom_range(1, 12));
				load_sym(sym[SYM_W-1:0], $urandom, len, 1'($urandom_range(0, 1)));
				if (len != 0 && len <= LEN_LIMIT)
					live_syms = {live_syms, sym};
			end
			n_enc = $urandom_range(1, 10);
			for (k = 0; k < n_enc; k++) begin
				if ($urandom_range(0, 4) != 0)
					sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
				else
					sym = $urandom_range(0, SYMBOL_COUNT - 1);
				encode_sym(sym[SYM_W-1:0], (k == n_enc - 1) && ($urandom_range(0, 5) != 0));
				n_items++;
			end
		end
		encode_sym(8'h00, 1'b1);
		s_tvalid <= 1'b0;

		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
